// File: hw/rtl/door_access_code_lock_controller_assert.svh
// Assertion macros used by the checker file of the door controller.
// Each macro expands to one labelled concurrent assertion clocked by clk
// and switched off while rst_n is low.
`ifndef DOOR_ACCESS_CODE_LOCK_CONTROLLER_ASSERT_SVH
`define DOOR_ACCESS_CODE_LOCK_CONTROLLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DACL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DACL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/dacl_pkg.sv
package dacl_pkg;

  // Event codes carried in the operation field.
  localparam logic [1:0] OP_KEY    = 2'd0;
  localparam logic [1:0] OP_CARD   = 2'd1;
  localparam logic [1:0] OP_SENSOR = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  // Door states.
  localparam logic [2:0] ST_IDLE        = 3'd0;
  localparam logic [2:0] ST_AWAIT_CARD  = 3'd1;
  localparam logic [2:0] ST_ALLOWED     = 3'd2;
  localparam logic [2:0] ST_CARD_FAILED = 3'd3;
  localparam logic [2:0] ST_ENTERING    = 3'd4;
  localparam logic [2:0] ST_CODE_WRONG  = 3'd5;

  // Code verdicts.
  localparam logic [1:0] VERDICT_PENDING = 2'd0;
  localparam logic [1:0] VERDICT_WRONG   = 2'd1;
  localparam logic [1:0] VERDICT_RIGHT   = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_PASS_CODE      = 1'b0;
  localparam logic CFG_TIMEOUT_PERIOD = 1'b1;

  localparam int unsigned CodeWidth    = 24;
  localparam int unsigned PeriodWidth  = 16;
  localparam int unsigned CfgWidth     = 24;
  localparam int unsigned StoredDigits = CodeWidth / 4;

  localparam logic [CodeWidth-1:0]   PASS_CODE_RESET      = 24'hB8FC28;
  localparam logic [PeriodWidth-1:0] TIMEOUT_PERIOD_RESET = 16'd1000;

  // x / 5 for any 16-bit x equals (x * 52429) >> 18.
  localparam logic [15:0] FIFTH_MUL   = 16'd52429;
  localparam int unsigned FifthShift  = 18;

  // Keypad digit, indexed by {row, column}.
  localparam logic [3:0] KEYPAD_DIGIT [0:15] = '{
    4'h1, 4'h2, 4'h3, 4'h4,
    4'h5, 4'h6, 4'h7, 4'h8,
    4'h9, 4'h0, 4'hA, 4'hB,
    4'hC, 4'hD, 4'hE, 4'hF
  };

  // Controller state other than the digit store and the digit count.
  typedef struct packed {
    logic [2:0]             access_state;
    logic                   relay_drive;
    logic                   presence_flag;
    logic [1:0]             verdict;
    logic [PeriodWidth-1:0] timer_left;
    logic                   timer_active;
  } dacl_status_t;

  // Code digit at a position; positions past the stored code compare with 0.
  function automatic logic [3:0] code_digit(logic [CodeWidth-1:0] code,
                                            logic [3:0] pos);
    logic [3:0] d;
    case (pos)
      4'd0:    d = code[3:0];
      4'd1:    d = code[7:4];
      4'd2:    d = code[11:8];
      4'd3:    d = code[15:12];
      4'd4:    d = code[19:16];
      4'd5:    d = code[23:20];
      default: d = 4'h0;
    endcase
    return d;
  endfunction

endpackage

// File: hw/rtl/dacl_step.sv
// Next-state logic for one event word.
module dacl_step #(
  parameter int unsigned CODE_DIGITS = 6,
  parameter int unsigned CntWidth    = 3,
  parameter int unsigned IdxWidth    = 3
) (
  input  dacl_pkg::dacl_status_t             st,
  input  logic [CntWidth-1:0]                cnt,
  input  logic [CODE_DIGITS*4-1:0]           digits,
  input  logic [dacl_pkg::CodeWidth-1:0]     pass_code,
  input  logic [dacl_pkg::PeriodWidth-1:0]   timeout_period,
  input  logic [1:0]                         operation,
  input  logic [1:0]                         key_row,
  input  logic [1:0]                         key_column,
  input  logic                               card_ok,
  input  logic                               sensor_state,
  input  logic                               line_level,
  output dacl_pkg::dacl_status_t             st_nxt,
  output logic [CntWidth-1:0]                cnt_nxt,
  output logic                               dig_we,
  output logic [IdxWidth-1:0]                dig_idx,
  output logic [3:0]                         dig_val,
  output logic                               fired
);

  logic [31:0]                       fifth_prod;
  logic [dacl_pkg::PeriodWidth-1:0]  fifth;
  logic [dacl_pkg::PeriodWidth-1:0]  reload;
  logic                              match;
  logic [3:0]                        cur_digit;

  assign fifth_prod = 32'(timeout_period) * 32'(dacl_pkg::FIFTH_MUL);
  assign fifth      = dacl_pkg::PeriodWidth'(fifth_prod[31:dacl_pkg::FifthShift]);
  assign dig_val    = dacl_pkg::KEYPAD_DIGIT[{key_row, key_column}];
  assign dig_idx    = cnt[IdxWidth-1:0];

  always_comb begin
    st_nxt  = st;
    cnt_nxt = cnt;
    dig_we  = 1'b0;
    fired   = 1'b0;
    match   = 1'b1;
    reload  = timeout_period;
    cur_digit = 4'h0;
    case (operation)
      dacl_pkg::OP_KEY: begin
        if (cnt < CntWidth'(CODE_DIGITS)) begin
          dig_we  = 1'b1;
          cnt_nxt = cnt + CntWidth'(1);
        end
        // Compare with the digit just written folded in.
        for (int i = 0; i < CODE_DIGITS; i++) begin
          cur_digit = (dig_we && dig_idx == IdxWidth'(i)) ? dig_val : digits[4*i +: 4];
          if (cur_digit != dacl_pkg::code_digit(pass_code, 4'(i))) begin
            match = 1'b0;
          end
        end
        if (cnt_nxt >= CntWidth'(CODE_DIGITS)) begin
          st_nxt.verdict = match ? dacl_pkg::VERDICT_RIGHT : dacl_pkg::VERDICT_WRONG;
        end
        case (st_nxt.verdict)
          dacl_pkg::VERDICT_RIGHT: begin
            reload              = {1'b0, timeout_period[dacl_pkg::PeriodWidth-1:1]};
            st_nxt.access_state = dacl_pkg::ST_ALLOWED;
            st_nxt.relay_drive  = 1'b1;
          end
          dacl_pkg::VERDICT_WRONG: begin
            reload              = fifth;
            st_nxt.access_state = dacl_pkg::ST_CODE_WRONG;
          end
          default: begin
            reload              = timeout_period;
            st_nxt.access_state = dacl_pkg::ST_ENTERING;
          end
        endcase
        st_nxt.timer_left   = (reload == '0) ? dacl_pkg::PeriodWidth'(1) : reload;
        st_nxt.timer_active = 1'b1;
      end
      dacl_pkg::OP_CARD: begin
        if (st.presence_flag) begin
          st_nxt.access_state = card_ok ? dacl_pkg::ST_ALLOWED : dacl_pkg::ST_CARD_FAILED;
          st_nxt.relay_drive  = card_ok;
        end
      end
      dacl_pkg::OP_SENSOR: begin
        if (sensor_state && line_level) begin
          st_nxt.presence_flag = 1'b1;
          st_nxt.access_state  = dacl_pkg::ST_AWAIT_CARD;
        end else if (!sensor_state && !line_level) begin
          st_nxt.presence_flag = 1'b0;
          st_nxt.access_state  = dacl_pkg::ST_IDLE;
          st_nxt.relay_drive   = 1'b0;
        end
      end
      default: begin
        if (st.timer_active) begin
          if (st.timer_left <= dacl_pkg::PeriodWidth'(1)) begin
            st_nxt.timer_left   = '0;
            st_nxt.timer_active = 1'b0;
            fired               = 1'b1;
            if (st.verdict == dacl_pkg::VERDICT_RIGHT) begin
              if (!st.presence_flag) begin
                st_nxt.access_state = dacl_pkg::ST_IDLE;
                st_nxt.relay_drive  = 1'b0;
              end
            end else if (st.verdict == dacl_pkg::VERDICT_WRONG) begin
              if (st.presence_flag) begin
                st_nxt.access_state = dacl_pkg::ST_AWAIT_CARD;
              end else begin
                st_nxt.access_state = dacl_pkg::ST_IDLE;
                st_nxt.relay_drive  = 1'b0;
              end
            end
            cnt_nxt        = '0;
            st_nxt.verdict = dacl_pkg::VERDICT_PENDING;
          end else begin
            st_nxt.timer_left = st.timer_left - dacl_pkg::PeriodWidth'(1);
          end
        end
      end
    endcase
  end

endmodule

// File: hw/rtl/door_access_code_lock_controller.sv
// Door access controller: keypad, card verdict, presence and tick events.
// Input channel: in_valid/in_stall carry one event word (operation plus its
// key, card and sensor fields). Result channel: out_valid/out_stall carry one
// status word per event, showing the door state after that event.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 pass code,
// 1 timeout period); the user must make writes only while no event is in
// flight, which the block itself does not enforce. An accepted event waits
// in the input register while the state update feeds the result register,
// which holds the status word. Throughput is one event per cycle while the
// receiver does not stall.
// When the receiver stalls, the status word holds and the event behind it
// waits in the input register; in_stall rises only once both are full, and
// drops in the cycle the result is taken.
// A synchronous reset (rst_n low) clears the controller to idle with no
// digits held, the timer stopped, relay off and both channels empty; the
// configuration registers return to their reset values. The digit store is
// not cleared: a code is only compared once every position is written.
module door_access_code_lock_controller #(
  parameter int unsigned CODE_DIGITS = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_operation,
  input  logic [1:0]                        in_key_row,
  input  logic [1:0]                        in_key_column,
  input  logic                              in_card_ok,
  input  logic                              in_sensor_state,
  input  logic                              in_line_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        out_door_state,
  output logic                              out_relay_on,
  output logic                              out_person_here,
  output logic [2:0]                        out_digits_entered,
  output logic [1:0]                        out_code_verdict,
  output logic                              out_timeout_fired,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [dacl_pkg::CfgWidth-1:0]     cfg_wdata
);

  // The count must reach CODE_DIGITS itself; the store index need not.
  localparam int unsigned CntWidth = $clog2(CODE_DIGITS + 1);
  localparam int unsigned IdxWidth = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

  // Configuration registers.
  logic [dacl_pkg::CodeWidth-1:0]   pass_code_r;
  logic [dacl_pkg::PeriodWidth-1:0] timeout_period_r;

  // Controller state.
  dacl_pkg::dacl_status_t st_r, st_nxt;
  logic [CntWidth-1:0]    cnt_r, cnt_nxt;
  logic [3:0]             digit_r [CODE_DIGITS];
  logic [CODE_DIGITS*4-1:0] digits_flat;

  // Input register.
  logic       in_vld_r;
  logic [1:0] op_r;
  logic [1:0] row_r;
  logic [1:0] col_r;
  logic       card_r;
  logic       sensor_r;
  logic       level_r;

  // Result register.
  logic       out_vld_r;
  logic [2:0] door_r;
  logic       relay_r;
  logic       person_r;
  logic [2:0] digits_r;
  logic [1:0] verdict_r;
  logic       fired_r;

  logic                in_take;
  logic                advance;
  logic                dig_we;
  logic [IdxWidth-1:0] dig_idx;
  logic [3:0]          dig_val;
  logic                fired;

  // An event moves into the result register whenever that register is empty
  // or its word is being taken in this cycle.
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    for (int i = 0; i < CODE_DIGITS; i++) begin
      digits_flat[4*i +: 4] = digit_r[i];
    end
  end

  dacl_step #(
    .CODE_DIGITS (CODE_DIGITS),
    .CntWidth    (CntWidth),
    .IdxWidth    (IdxWidth)
  ) u_step (
    .st             (st_r),
    .cnt            (cnt_r),
    .digits         (digits_flat),
    .pass_code      (pass_code_r),
    .timeout_period (timeout_period_r),
    .operation      (op_r),
    .key_row        (row_r),
    .key_column     (col_r),
    .card_ok        (card_r),
    .sensor_state   (sensor_r),
    .line_level     (level_r),
    .st_nxt         (st_nxt),
    .cnt_nxt        (cnt_nxt),
    .dig_we         (dig_we),
    .dig_idx        (dig_idx),
    .dig_val        (dig_val),
    .fired          (fired)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_code_r      <= dacl_pkg::PASS_CODE_RESET;
      timeout_period_r <= dacl_pkg::TIMEOUT_PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dacl_pkg::CFG_PASS_CODE:      pass_code_r      <= cfg_wdata[dacl_pkg::CodeWidth-1:0];
        dacl_pkg::CFG_TIMEOUT_PERIOD: timeout_period_r <= cfg_wdata[dacl_pkg::PeriodWidth-1:0];
        default: ;
      endcase
    end
  end

  // Control state and handshake flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= '{access_state: dacl_pkg::ST_IDLE, verdict: dacl_pkg::VERDICT_PENDING,
                     default: '0};
      cnt_r     <= '0;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (advance) begin
        st_r  <= st_nxt;
        cnt_r <= cnt_nxt;
      end
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers and the digit store carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r     <= in_operation;
      row_r    <= in_key_row;
      col_r    <= in_key_column;
      card_r   <= in_card_ok;
      sensor_r <= in_sensor_state;
      level_r  <= in_line_level;
    end
    if (advance && dig_we) begin
      digit_r[dig_idx] <= dig_val;
    end
    if (advance) begin
      door_r    <= st_nxt.access_state;
      relay_r   <= st_nxt.relay_drive;
      person_r  <= st_nxt.presence_flag;
      digits_r  <= 3'(cnt_nxt);
      verdict_r <= st_nxt.verdict;
      fired_r   <= fired;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_door_state     = door_r;
  assign out_relay_on       = relay_r;
  assign out_person_here    = person_r;
  assign out_digits_entered = digits_r;
  assign out_code_verdict   = verdict_r;
  assign out_timeout_fired  = fired_r;

endmodule

// File: hw/rtl/dacl_checker.sv
`include "door_access_code_lock_controller_assert.svh"

// Port-level checks on the result channel of the door controller.
module dacl_checker #(
  parameter int unsigned CODE_DIGITS = 6
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_door_state,
  input logic       out_relay_on,
  input logic       out_person_here,
  input logic [2:0] out_digits_entered,
  input logic [1:0] out_code_verdict,
  input logic       out_timeout_fired
);

  // A verdict is only given once the whole code has been keyed in.
  `DACL_ASSERT_SAME(a_verdict_full, out_valid && out_code_verdict != dacl_pkg::VERDICT_PENDING, out_digits_entered == 3'(CODE_DIGITS), "verdict without a full entry")

  // An expired timeout always leaves the entry cleared.
  `DACL_ASSERT_SAME(a_fire_clears, out_valid && out_timeout_fired, out_digits_entered == 3'd0 && out_code_verdict == dacl_pkg::VERDICT_PENDING, "timeout left entry behind")

  // A stalled status word is held until it is taken.
  `DACL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_door_state) && $stable(out_relay_on) && $stable(out_person_here) && $stable(out_digits_entered) && $stable(out_code_verdict) && $stable(out_timeout_fired), "stalled status word changed")

endmodule

bind door_access_code_lock_controller dacl_checker #(
  .CODE_DIGITS (CODE_DIGITS)
) u_dacl_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_door_state     (out_door_state),
  .out_relay_on       (out_relay_on),
  .out_person_here    (out_person_here),
  .out_digits_entered (out_digits_entered),
  .out_code_verdict   (out_code_verdict),
  .out_timeout_fired  (out_timeout_fired)
);
